[design/ptts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared types and sizes for the periodic task tick scheduler.
// ----------------------------------------------------------------------------
package ptts_pkg;

  localparam int NUM_SLOTS   = 8;
  localparam int MAX_RESULTS = 8;
  localparam int IDX_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W       = $clog2(NUM_SLOTS + 1);
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  localparam int SLOT_W      = 4;
  localparam int TIME_W      = 16;
  localparam int TASK_IDX_W  = 3;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 8;

  localparam logic FUNC_TICK     = 1'b0;
  localparam logic FUNC_REGISTER = 1'b1;
  localparam logic KIND_STATUS   = 1'b0;
  localparam logic KIND_DUE      = 1'b1;
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_ERR    = 1'b1;

  typedef logic [TIME_W-1:0] time_t;

  typedef struct packed {
    time_t period;
    time_t countdown;
  } slot_entry_t;

endpackage

[design/periodic_task_tick_scheduler_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_top
// Tick scheduler over a table of task slots held in a synchronous memory.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | tuser func, tdata slot/first_delay/period
//  out_    | out | out_tvalid/out_tready| tuser kind, tdata task_index/status, tlast
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_data tick_step
//
//  a tick makes one memory read per slot, overlapped with the write-back of the
//  slot before, plus a start step and a flush step (ST_FLUSH)
//  a registration passes through ST_REG, which writes a free in-range slot and returns a status
//  output stalls hold the slot walk only when a second due result must leave
//  rst_n clears state, slot used bits and tick_step (to 1); the memory is not cleared
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ptts_pkg::IN_DATA_W-1:0]  in_tdata,   // slot[3:0], first_delay[19:4], period[35:20]
  input  logic                            in_tuser,   // func
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ptts_pkg::OUT_DATA_W-1:0] out_tdata,  // task_index[2:0], status[3]
  output logic                            out_tuser,  // kind
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ptts_pkg::TIME_W-1:0]     cfg_data
);
  import ptts_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FLUSH, ST_REG} state_t;

  state_t                state_r, state_nxt;
  time_t                 tick_step_r;
  logic [NUM_SLOTS-1:0]  used_r, used_nxt;
  logic [CNT_W-1:0]      ptr_r, ptr_nxt;
  logic                  proc_v_r, proc_v_nxt;
  logic [IDX_W-1:0]      proc_idx_r, proc_idx_nxt;
  logic                  pend_v_r, pend_v_nxt;
  logic [TASK_IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic [RES_W-1:0]      res_cnt_r, res_cnt_nxt;
  logic [SLOT_W-1:0]     reg_slot_r, reg_slot_nxt;
  time_t                 reg_first_r, reg_first_nxt;
  time_t                 reg_period_r, reg_period_nxt;
  logic                  out_v_r, out_v_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_user_r, out_user_nxt;
  logic                  out_last_r, out_last_nxt;

  slot_entry_t           mem [NUM_SLOTS];
  slot_entry_t           rdata_r;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  slot_entry_t           wdata;

  logic                  out_free;
  logic                  proc_used;
  logic                  proc_due;
  logic                  proc_report;
  logic                  scan_stall;
  logic                  advance;
  logic                  ptr_done;
  logic [SLOT_W-1:0]     proc_idx4;
  logic                  reg_in_range;
  logic [IDX_W-1:0]      reg_idx;
  logic                  reg_ok;
  time_t                 new_cd;

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  assign out_free     = !out_v_r || out_tready;
  assign proc_used    = used_r[proc_idx_r];
  assign proc_due     = proc_v_r && proc_used && (rdata_r.countdown == '0);
  assign proc_report  = proc_due && (res_cnt_r < RES_W'(MAX_RESULTS));
  assign scan_stall   = proc_report && pend_v_r && !out_free;
  assign advance      = (state_r == ST_SCAN) && !scan_stall;
  assign ptr_done     = (ptr_r == CNT_W'(NUM_SLOTS));
  assign proc_idx4    = SLOT_W'(proc_idx_r);
  assign reg_in_range = ({1'b0, reg_slot_r} < (SLOT_W + 1)'(NUM_SLOTS));
  assign reg_idx      = reg_slot_r[IDX_W-1:0];
  assign reg_ok       = reg_in_range && !used_r[reg_idx];

  // saturating countdown step, reloading the period when the countdown is zero
  always_comb begin
    if (rdata_r.countdown == '0) begin
      new_cd = rdata_r.period;
    end else if (rdata_r.countdown <= tick_step_r) begin
      new_cd = '0;
    end else begin
      new_cd = rdata_r.countdown - tick_step_r;
    end
  end

  assign rd_en   = advance && !ptr_done;
  assign rd_addr = ptr_r[IDX_W-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = proc_idx_r;
    wdata   = '{period: rdata_r.period, countdown: new_cd};
    if (advance && proc_v_r && proc_used) begin
      wr_en = 1'b1;
    end else if (state_r == ST_REG && out_free && reg_ok) begin
      wr_en   = 1'b1;
      wr_addr = reg_idx;
      wdata   = '{period: reg_period_r, countdown: reg_first_r};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    ptr_nxt        = ptr_r;
    proc_v_nxt     = proc_v_r;
    proc_idx_nxt   = proc_idx_r;
    pend_v_nxt     = pend_v_r;
    pend_idx_nxt   = pend_idx_r;
    res_cnt_nxt    = res_cnt_r;
    reg_slot_nxt   = reg_slot_r;
    reg_first_nxt  = reg_first_r;
    reg_period_nxt = reg_period_r;
    out_v_nxt      = out_v_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          reg_slot_nxt   = in_tdata[3:0];
          reg_first_nxt  = in_tdata[19:4];
          reg_period_nxt = in_tdata[35:20];
          ptr_nxt        = '0;
          proc_v_nxt     = 1'b0;
          pend_v_nxt     = 1'b0;
          res_cnt_nxt    = '0;
          state_nxt      = (in_tuser == FUNC_REGISTER) ? ST_REG : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (advance) begin
          // a new due slot pushes the held one out, not yet known to be last
          if (proc_report) begin
            if (pend_v_r) begin
              out_v_nxt    = 1'b1;
              out_user_nxt = KIND_DUE;
              out_data_nxt = OUT_DATA_W'({STATUS_OK, pend_idx_r});
              out_last_nxt = 1'b0;
            end
            pend_v_nxt   = 1'b1;
            pend_idx_nxt = proc_idx4[TASK_IDX_W-1:0];
            res_cnt_nxt  = res_cnt_r + 1'b1;
          end
          if (!ptr_done) begin
            proc_v_nxt   = 1'b1;
            proc_idx_nxt = rd_addr;
            ptr_nxt      = ptr_r + 1'b1;
          end else begin
            proc_v_nxt = 1'b0;
            if (!proc_v_r) begin
              state_nxt = ST_FLUSH;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_v_nxt    = 1'b1;
          out_user_nxt = KIND_DUE;
          out_data_nxt = OUT_DATA_W'({STATUS_OK, pend_idx_r});
          out_last_nxt = 1'b1;
          pend_v_nxt   = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      ST_REG: begin
        if (out_free) begin
          if (reg_ok) begin
            used_nxt[reg_idx] = 1'b1;
          end
          out_v_nxt    = 1'b1;
          out_user_nxt = KIND_STATUS;
          out_data_nxt = OUT_DATA_W'({(reg_ok ? STATUS_OK : STATUS_ERR), TASK_IDX_W'(0)});
          out_last_nxt = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tick_step_r <= TIME_W'(1);
      used_r      <= '0;
      ptr_r       <= '0;
      proc_v_r    <= 1'b0;
      pend_v_r    <= 1'b0;
      res_cnt_r   <= '0;
      out_v_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      used_r   <= used_nxt;
      ptr_r    <= ptr_nxt;
      proc_v_r <= proc_v_nxt;
      pend_v_r <= pend_v_nxt;
      res_cnt_r <= res_cnt_nxt;
      out_v_r  <= out_v_nxt;
      if (cfg_valid) begin
        tick_step_r <= cfg_data;
      end
    end
    proc_idx_r   <= proc_idx_nxt;
    pend_idx_r   <= pend_idx_nxt;
    reg_slot_r   <= reg_slot_nxt;
    reg_first_r  <= reg_first_nxt;
    reg_period_r <= reg_period_nxt;
    out_data_r   <= out_data_nxt;
    out_user_r   <= out_user_nxt;
    out_last_r   <= out_last_nxt;
  end

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= CNT_W'(NUM_SLOTS))
    else $error("slot pointer past table end");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en && wr_en |-> rd_addr != wr_addr)
    else $error("memory read and write hit the same slot");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !proc_v_r && !pend_v_r)
    else $error("idle with a slot or result still in flight");

  a_tick_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == FUNC_TICK |=> state_r == ST_SCAN && ptr_r == '0)
    else $error("tick did not start a slot walk");

  a_emit_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the periodic task tick scheduler. A scoreboard class keeps
// its own copy of the slot table and tick step. For every accepted tick or
// registration it predicts the status or due-task results, which are
// compared in order with what leaves the result stream. Both streams idle
// at random. tick_step is rewritten between phases, including zero and
// full scale.
// ----------------------------------------------------------------------------
module tb_top;
  import ptts_pkg::*;

  localparam int HALF_PERIOD     = 6;
  localparam int RESET_CYCLES    = 8;
  localparam int SETTLE_CYCLES   = 20;
  localparam int STALL_LIMIT     = 4000;
  localparam int MAX_GAP         = 8;
  localparam int RANDOM_PHASES   = 5;
  localparam int ITEMS_PER_PHASE = 40;
  localparam int REPORT_LIMIT    = 10;
  localparam int PAD_W           = IN_DATA_W - 2 * TIME_W - SLOT_W;

  typedef struct packed {
    logic                  kind;
    logic [TASK_IDX_W-1:0] task_index;
    logic                  status;
    logic                  last;
  } sched_result_t;

  class sched_scoreboard;
    time_t         tick_step;
    bit            slot_busy [NUM_SLOTS];
    time_t         countdown [NUM_SLOTS];
    time_t         reload [NUM_SLOTS];
    sched_result_t expected_q[$];
    int            mismatches;
    int            checked;
    int            due_seen;

    function new();
      tick_step  = 1;
      mismatches = 0;
      checked    = 0;
      due_seen   = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_busy[i] = 1'b0;
        countdown[i] = '0;
        reload[i]    = '0;
      end
    endfunction

    function void set_step(time_t step);
      tick_step = step;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // predict the results of one accepted item and update the slot table
    function void note_item(logic func, logic [SLOT_W-1:0] slot, time_t first_delay,
                            time_t period);
      sched_result_t res [MAX_RESULTS];
      sched_result_t r;
      int            n;
      int            idx;
      n   = 0;
      idx = int'(slot);
      if (func == FUNC_REGISTER) begin
        r.kind       = KIND_STATUS;
        r.task_index = '0;
        r.status     = STATUS_ERR;
        r.last       = 1'b1;
        if (idx < NUM_SLOTS) begin
          if (!slot_busy[idx]) begin
            slot_busy[idx] = 1'b1;
            countdown[idx] = first_delay;
            reload[idx]    = period;
            r.status       = STATUS_OK;
          end
        end
        expected_q.push_back(r);
      end else begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_busy[i]) begin
            if (countdown[i] == '0) begin
              // every due slot reloads, even past the per-tick report cap
              if (n < MAX_RESULTS) begin
                res[n].kind       = KIND_DUE;
                res[n].task_index = TASK_IDX_W'(i);
                res[n].status     = STATUS_OK;
                res[n].last       = 1'b0;
                n++;
              end
              countdown[i] = reload[i];
            end else if (countdown[i] <= tick_step) begin
              countdown[i] = '0;
            end else begin
              countdown[i] = countdown[i] - tick_step;
            end
          end
        end
        if (n > 0) res[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) expected_q.push_back(res[k]);
      end
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("[%0t] mismatch: %s", $time, what);
    endfunction

    function void check_result(sched_result_t got);
      sched_result_t want;
      if (expected_q.size() == 0) begin
        flag($sformatf("unexpected result kind=%0d index=%0d status=%0d last=%0d",
                       got.kind, got.task_index, got.status, got.last));
      end else begin
        want = expected_q.pop_front();
        checked++;
        if (want.kind == KIND_DUE) due_seen++;
        if (got.kind != want.kind || got.task_index != want.task_index ||
            got.status != want.status || got.last != want.last) begin
          flag($sformatf({"expected kind=%0d index=%0d status=%0d last=%0d, ",
                          "actual kind=%0d index=%0d status=%0d last=%0d"},
                         want.kind, want.task_index, want.status, want.last,
                         got.kind, got.task_index, got.status, got.last));
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // slot[3:0], first_delay[19:4], period[35:20]
  logic                  in_tuser;   // func
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // task_index[2:0], status[3]
  logic                  out_tuser;  // kind
  logic                  out_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [TIME_W-1:0]     cfg_data;

  sched_scoreboard sb = new();

  int items_sent;
  int regs_sent;
  int ticks_sent;
  int steps_written;
  int idle_cycles;
  bit tx_calm;
  bit rx_calm;

  periodic_task_tick_scheduler_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // valid stays high across back-to-back items, so it is only lowered before a gap
  task automatic send_item(input logic func, input logic [SLOT_W-1:0] slot,
                           input time_t first_delay, input time_t period);
    int gap;
    if (items_sent % 16 == 0) tx_calm = ($urandom_range(0, 3) == 0);
    gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {{PAD_W{1'b0}}, period, first_delay, slot};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(func, slot, first_delay, period);
    items_sent++;
    if (func == FUNC_REGISTER) regs_sent++;
    else ticks_sent++;
  endtask

  task automatic send_random();
    logic              func;
    logic [SLOT_W-1:0] slot;
    time_t             first_delay;
    time_t             period;
    func = ($urandom_range(0, 4) == 0) ? FUNC_REGISTER : FUNC_TICK;
    slot = SLOT_W'($urandom_range(0, 15));
    // short delays keep tasks firing, full-range values toggle every bit
    if ($urandom_range(0, 1) == 1) begin
      first_delay = TIME_W'($urandom_range(0, 12));
      period      = TIME_W'($urandom_range(0, 12));
    end else begin
      first_delay = TIME_W'($urandom());
      period      = TIME_W'($urandom());
    end
    send_item(func, slot, first_delay, period);
  endtask

  // a tick with nothing due leaves no trace, so give it time to finish
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tick_step(input time_t step);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= step;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_step(step);
    steps_written++;
  endtask

  initial begin : result_sink
    sched_result_t got;
    int            gap;
    int            n;
    n = 0;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (n % 16 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      gap = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      got.kind       = out_tuser;
      got.task_index = out_tdata[TASK_IDX_W-1:0];
      got.status     = out_tdata[TASK_IDX_W];
      got.last       = out_tlast;
      sb.check_result(got);
      n++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[%0t] timeout: no handshake for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, sb.pending());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    time_t phase_step [RANDOM_PHASES];
    items_sent    = 0;
    regs_sent     = 0;
    ticks_sent    = 0;
    steps_written = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= FUNC_TICK;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, then zero period, taken slot, out of range, extremes
    send_item(FUNC_TICK, 4'd0, 16'h0000, 16'h0000);
    send_item(FUNC_REGISTER, 4'd0, 16'h0000, 16'h0000);
    send_item(FUNC_REGISTER, 4'd0, 16'h0005, 16'h0005);
    send_item(FUNC_REGISTER, 4'd8, 16'h1234, 16'h4321);
    send_item(FUNC_REGISTER, 4'd15, 16'hffff, 16'hffff);
    send_item(FUNC_REGISTER, 4'd7, 16'hffff, 16'hffff);
    send_item(FUNC_REGISTER, 4'd3, 16'h0002, 16'h0001);
    repeat (4) send_item(FUNC_TICK, 4'd0, 16'h0000, 16'h0000);

    // zero step: only slots already at zero fire
    write_tick_step(16'h0000);
    repeat (3) send_item(FUNC_TICK, 4'd15, 16'hffff, 16'hffff);

    // full-scale step: every nonzero countdown is at most the step and saturates to zero
    write_tick_step(16'hffff);
    repeat (4) send_item(FUNC_TICK, 4'd0, 16'h0000, 16'h0000);
    send_item(FUNC_REGISTER, 4'd5, 16'haaaa, 16'h5555);
    send_item(FUNC_REGISTER, 4'd6, 16'h5555, 16'haaaa);
    repeat (3) send_item(FUNC_TICK, 4'd0, 16'h0000, 16'h0000);

    phase_step[0] = 16'h0001;
    phase_step[1] = 16'hffff;
    phase_step[2] = 16'h0000;
    phase_step[3] = TIME_W'($urandom_range(2, 9));
    phase_step[4] = TIME_W'($urandom_range(1, 65535));
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_tick_step(phase_step[p]);
      repeat (ITEMS_PER_PHASE) send_random();
    end

    wait_idle();
    if (sb.pending() != 0) sb.flag($sformatf("%0d results never arrived", sb.pending()));
    $display("summary: %0d items sent (%0d registrations, %0d ticks), %0d results checked",
             items_sent, regs_sent, ticks_sent, sb.checked);
    $display("summary: %0d due reports, tick_step rewritten %0d times incl. zero and max",
             sb.due_seen, steps_written);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[periodic_task_tick_scheduler_top.f]
design/ptts_pkg.sv
design/periodic_task_tick_scheduler_top.sv
test/tb_top.sv
